// ===== rtl/thtp_pkg.sv =====
// ----------------------------------------------------------------------------
// thtp_pkg
// Shared types and codes for the twelve-hour time text parser.
// ----------------------------------------------------------------------------
package thtp_pkg;

  // Error codes reported with a result (first error wins)
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_HOUR_RANGE    = 3'd1;
  localparam logic [2:0] ERR_HOUR_DIGITS   = 3'd2;
  localparam logic [2:0] ERR_HOUR_CHAR     = 3'd3;
  localparam logic [2:0] ERR_MINUTE_RANGE  = 3'd4;
  localparam logic [2:0] ERR_MINUTE_DIGITS = 3'd5;
  localparam logic [2:0] ERR_MINUTE_CHAR   = 3'd6;
  localparam logic [2:0] ERR_MERIDIEM      = 3'd7;

  // One result item
  typedef struct packed {
    logic [10:0] minute_of_day;
    logic [2:0]  error_code;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
  } thtp_result_t;

endpackage

// ===== rtl/thtp_if.sv =====
// ----------------------------------------------------------------------------
// thtp_in_if / thtp_out_if
// Valid/ready channels for characters in and parsed times out.
// ----------------------------------------------------------------------------
interface thtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

interface thtp_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] minute_of_day;
  logic [2:0]  error_code;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;

  modport source (output valid, output minute_of_day, output error_code,
                  output hour_of_day, output minute_of_hour, input ready);
  modport sink   (input valid, input minute_of_day, input error_code,
                  input hour_of_day, input minute_of_hour, output ready);
endinterface

// ===== rtl/twelve_hour_time_text_parser.sv =====
// ----------------------------------------------------------------------------
// twelve_hour_time_text_parser
// Parses "hh:mm am" style text, one character per transfer, into a 24-hour
// time and minutes after midnight.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one ASCII character per transfer, end_of_text set on the
//              final character of a text.
//   out_chan : one result per text, sent for the end_of_text character:
//              minute_of_day, hour_of_day, minute_of_hour, error_code
//              (time fields are zero when error_code is nonzero).
//   Throughput is one character per cycle, except while a final character
//   waits for the output register. A character is held in the input
//   register; the result of a final character is loaded into the output
//   register as that character leaves it, and out_chan.valid then rises.
//   The parse state updates in one pass of compare/accumulate logic and the
//   result arithmetic (mod 24, times 60) sits in the same pass.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the hours phase. When the receiver stalls, characters that are
//   not final keep flowing; a final character waits in the input register,
//   with in_chan.ready low, until the output register frees.
// ----------------------------------------------------------------------------
module twelve_hour_time_text_parser
  import thtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  thtp_in_if.sink     in_chan,
  thtp_out_if.source  out_chan
);

  logic         s1_valid_r;
  logic [7:0]   s1_char_r;
  logic         s1_last_r;
  logic         out_valid_r;
  thtp_result_t out_data_r;
  thtp_result_t result;
  logic         out_free;
  logic         s1_go;

  // Stage handshake
  assign out_free       = !out_valid_r || out_chan.ready;
  assign s1_go          = s1_valid_r && (!s1_last_r || out_free);
  assign in_chan.ready  = !s1_valid_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_char_r <= in_chan.character;
      s1_last_r <= in_chan.end_of_text;
    end
  end

  // Parser
  thtp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_go),
    .step_char (s1_char_r),
    .step_last (s1_last_r),
    .result    (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.minute_of_day  = out_data_r.minute_of_day;
  assign out_chan.error_code     = out_data_r.error_code;
  assign out_chan.hour_of_day    = out_data_r.hour_of_day;
  assign out_chan.minute_of_hour = out_data_r.minute_of_hour;

endmodule

// ===== rtl/thtp_parse.sv =====
// ----------------------------------------------------------------------------
// thtp_parse
// Parse state machine: consumes one character per step and presents the
// result computed from the updated state. State returns to reset after the
// last character of a text.
// ----------------------------------------------------------------------------
module thtp_parse
  import thtp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  logic [7:0]   step_char,
  input  logic         step_last,
  output thtp_result_t result
);

  localparam logic [1:0] PH_HOURS    = 2'd0;
  localparam logic [1:0] PH_MINUTES  = 2'd1;
  localparam logic [1:0] PH_MERIDIEM = 2'd2;

  logic [1:0] phase_r,  phase_nxt;
  logic [1:0] dcnt_r,   dcnt_nxt;
  logic [6:0] hour_r,   hour_nxt;
  logic [6:0] minute_r, minute_nxt;
  logic       pm_r,     pm_nxt;
  logic       open_r,   open_nxt;
  logic       stop_r,   stop_nxt;
  logic [2:0] err_r,    err_nxt;

  logic       is_digit;
  logic [3:0] digit;

  assign is_digit = step_char inside {[8'h30:8'h39]};
  assign digit    = 4'(step_char - 8'h30);

  // Consume one character
  always_comb begin
    phase_nxt  = phase_r;
    dcnt_nxt   = dcnt_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    pm_nxt     = pm_r;
    open_nxt   = open_r;
    stop_nxt   = stop_r;
    err_nxt    = err_r;
    if (!stop_r && err_r == ERR_NONE) begin
      if (step_char == 8'h00 || step_char == 8'h0A) begin
        stop_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_HOURS: begin
            if (step_char == 8'h3A) begin
              if (hour_r > 7'd12) begin
                err_nxt = ERR_HOUR_RANGE;
              end else begin
                phase_nxt = PH_MINUTES;
                dcnt_nxt  = 2'd0;
              end
            end else if (is_digit) begin
              if (dcnt_r >= 2'd2) begin
                err_nxt = ERR_HOUR_DIGITS;
              end else begin
                dcnt_nxt = dcnt_r + 2'd1;
                hour_nxt = 7'(hour_r * 7'd10 + 7'(digit));
              end
            end else begin
              err_nxt = ERR_HOUR_CHAR;
            end
          end
          PH_MINUTES: begin
            if (step_char == 8'h20) begin
              if (minute_r > 7'd59) begin
                err_nxt = ERR_MINUTE_RANGE;
              end else begin
                phase_nxt = PH_MERIDIEM;
                dcnt_nxt  = 2'd0;
              end
            end else if (is_digit) begin
              if (dcnt_r >= 2'd2) begin
                err_nxt = ERR_MINUTE_DIGITS;
              end else begin
                dcnt_nxt   = dcnt_r + 2'd1;
                minute_nxt = 7'(minute_r * 7'd10 + 7'(digit));
              end
            end else begin
              err_nxt = ERR_MINUTE_CHAR;
            end
          end
          PH_MERIDIEM: begin
            if (step_char == 8'h61 || step_char == 8'h41) begin
              open_nxt = 1'b1;
            end else if (step_char == 8'h70 || step_char == 8'h50) begin
              open_nxt = 1'b1;
              pm_nxt   = 1'b1;
            end else if (step_char == 8'h6D || step_char == 8'h4D) begin
              if (open_r) stop_nxt = 1'b1;
            end else begin
              err_nxt = ERR_MERIDIEM;
            end
          end
          default: begin
            // unused phase: ignore
          end
        endcase
      end
    end
  end

  // Result from the updated state
  logic       pm_eff;
  logic       min_carry;
  logic [5:0] min_rem;
  logic [6:0] hour_tot;
  logic [6:0] h1, h2;
  logic [4:0] hod;

  always_comb begin
    pm_eff    = pm_nxt ^ (hour_nxt == 7'd12);
    min_carry = minute_nxt >= 7'd60;
    min_rem   = min_carry ? 6'(minute_nxt - 7'd60) : minute_nxt[5:0];
    hour_tot  = hour_nxt + (pm_eff ? 7'd12 : 7'd0) + {6'd0, min_carry};
    // reduce mod 24 (hour_tot is below 120)
    h1        = (hour_tot >= 7'd96) ? hour_tot - 7'd96 : hour_tot;
    h2        = (h1 >= 7'd48) ? h1 - 7'd48 : h1;
    hod       = (h2 >= 7'd24) ? 5'(h2 - 7'd24) : h2[4:0];
    if (err_nxt != ERR_NONE) begin
      result = '{minute_of_day: 11'd0, error_code: err_nxt,
                 hour_of_day: 5'd0, minute_of_hour: 6'd0};
    end else begin
      result.minute_of_day  = ({hod, 6'd0} - {4'd0, hod, 2'd0}) + {5'd0, min_rem};
      result.error_code     = ERR_NONE;
      result.hour_of_day    = hod;
      result.minute_of_hour = min_rem;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && step_last)) begin
      phase_r  <= PH_HOURS;
      dcnt_r   <= 2'd0;
      hour_r   <= 7'd0;
      minute_r <= 7'd0;
      pm_r     <= 1'b0;
      open_r   <= 1'b0;
      stop_r   <= 1'b0;
      err_r    <= ERR_NONE;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      dcnt_r   <= dcnt_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      pm_r     <= pm_nxt;
      open_r   <= open_nxt;
      stop_r   <= stop_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule
